@@ hw/rtl/rgbdith_pkg.sv @@
// Package for the RGB565 to 2bpp gray dither packer.
// Holds beat types, lane count and quantizer thresholds; no dependencies.
`timescale 1ns / 1ps

package rgbdith_pkg;

    localparam int NUM_LANES = 8;
    localparam int LVL_W     = 2;
    localparam int GRAY_W    = 8;

    localparam logic [GRAY_W-1:0] TH_0 = 8'd21;
    localparam logic [GRAY_W-1:0] TH_1 = 8'd42;
    localparam logic [GRAY_W-1:0] TH_2 = 8'd63;
    localparam logic [GRAY_W-1:0] TH_3 = 8'd84;
    localparam logic [GRAY_W-1:0] TH_4 = 8'd105;
    localparam logic [GRAY_W-1:0] TH_5 = 8'd126;

    typedef struct packed {
        logic [15:0] pixel_0;
        logic [15:0] pixel_1;
        logic [15:0] pixel_2;
        logic [15:0] pixel_3;
        logic [15:0] pixel_4;
        logic [15:0] pixel_5;
        logic [15:0] pixel_6;
        logic [15:0] pixel_7;
        logic        row_odd;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] byte_sent_first;
        logic [7:0] byte_sent_second;
    } t_pix_out;

    typedef logic [NUM_LANES-1:0][LVL_W-1:0] t_levels;

endpackage

@@ hw/rtl/rgbdith_lane.sv @@
// One pixel lane: RGB565 to gray, dithered 2-bit quantize, registered level.
// Depends on rgbdith_pkg.
`timescale 1ns / 1ps

module rgbdith_lane
    import rgbdith_pkg::*;
(
    input  logic             i_clk,
    input  logic [15:0]      i_pixel,
    input  logic             i_dither,
    output logic [LVL_W-1:0] o_level
);

    logic [LVL_W-1:0]  r_level;
    logic [LVL_W-1:0]  n_level;
    logic [4:0]        red;
    logic [5:0]        grn;
    logic [4:0]        blu;
    logic [8:0]        sum_rg;
    logic [8:0]        sum_b;
    logic [GRAY_W-1:0] gray;
    logic [LVL_W-1:0]  dbit;

    assign red    = i_pixel[15:11];
    assign grn    = i_pixel[10:5];
    assign blu    = i_pixel[4:0];
    assign sum_rg = {1'b0, red, 3'b000} + {1'b0, grn, 2'b00};
    assign sum_b  = {1'b0, sum_rg[8:1]} + {1'b0, blu, 3'b000};
    assign gray   = sum_b[8:1];
    assign dbit   = {1'b0, i_dither};

    always_comb begin
        if (gray < TH_0) begin
            n_level = 2'd3;
        end else if (gray < TH_1) begin
            n_level = 2'd3 - dbit;
        end else if (gray < TH_2) begin
            n_level = 2'd2;
        end else if (gray < TH_3) begin
            n_level = 2'd2 - dbit;
        end else if (gray < TH_4) begin
            n_level = 2'd1;
        end else if (gray < TH_5) begin
            n_level = 2'd1 - dbit;
        end else begin
            n_level = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_level <= n_level;
    end

    assign o_level = r_level;

endmodule

@@ hw/rtl/rgbdith_merge.sv @@
// Merge stage: packs the eight lane levels into two bytes in send order.
// Depends on rgbdith_pkg.
`timescale 1ns / 1ps

module rgbdith_merge
    import rgbdith_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_levels  i_levels,
    output logic     o_valid,
    output t_pix_out o_out
);

    logic            r_valid;
    t_pix_out        r_out;
    t_pix_out        n_out;
    logic [15:0]     flat;

    assign flat = i_levels;

    always_comb begin
        n_out.byte_sent_first  = flat[15:8];
        n_out.byte_sent_second = flat[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

@@ hw/rtl/rgb565_to_2bpp_dither_packer.sv @@
// Top level of the RGB565 to 2bpp gray dither packer.
// Depends on rgbdith_pkg, rgbdith_lane and rgbdith_merge.
//
// Takes one beat of eight RGB565 pixels per clock when start is high; busy
// is always low. Eight lanes quantize the pixels in parallel and a merge
// stage packs them. The two-byte result shows on o_out with o_valid high for
// one cycle, after the lane level registers and the merge output register.
// The receiver cannot stall: each result must be taken in the cycle it is
// shown.
`timescale 1ns / 1ps

module rgb565_to_2bpp_dither_packer
    import rgbdith_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_pix_in  i_pix,
    output logic     o_valid,
    output t_pix_out o_out
);

    logic [NUM_LANES-1:0][15:0] lane_px;
    t_levels                    levels;
    logic                       r_s1_valid;

    assign busy = 1'b0;

    assign lane_px[0] = i_pix.pixel_0;
    assign lane_px[1] = i_pix.pixel_1;
    assign lane_px[2] = i_pix.pixel_2;
    assign lane_px[3] = i_pix.pixel_3;
    assign lane_px[4] = i_pix.pixel_4;
    assign lane_px[5] = i_pix.pixel_5;
    assign lane_px[6] = i_pix.pixel_6;
    assign lane_px[7] = i_pix.pixel_7;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        // odd pixels dither on the inverted row parity
        rgbdith_lane u_lane (
            .i_clk    (i_clk),
            .i_pixel  (lane_px[g]),
            .i_dither (i_pix.row_odd ^ ((g % 2) == 1)),
            .o_level  (levels[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start & ~busy;
        end
    end

    rgbdith_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid),
        .i_levels (levels),
        .o_valid  (o_valid),
        .o_out    (o_out)
    );

endmodule

@@ tb/rgb565_to_2bpp_dither_packer_tb.sv @@
// Testbench for rgb565_to_2bpp_dither_packer: a directed table, then random pixel
// groups, each checked against typed bytes or a local gray, dither and pack predictor.
// Depends on rgbdith_pkg and the packer RTL.
`timescale 1ns / 1ps

module rgb565_to_2bpp_dither_packer_tb;
    import rgbdith_pkg::*;

    localparam int RAND_BEATS = 1150;
    localparam int DRAIN_MAX  = 1000;

    typedef struct {
        t_pix_in  beat;
        bit       typed;
        t_pix_out bytes;
    } t_dir_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_pix_in  i_pix;
    logic     o_valid;
    t_pix_out o_out;

    bit       typed_valid;
    t_pix_out typed_bytes;
    t_pix_out want_bytes;
    t_pix_out expected_bytes[$];
    t_dir_row dir_tab[$];
    int       th_list[6];
    int       err_count;
    int       beats_sent;
    int       pairs_checked;

    rgb565_to_2bpp_dither_packer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_pix   (i_pix),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    always #10 i_clk = ~i_clk;

    function automatic int px_gray(input logic [15:0] px);
        int r, g, b;
        r = int'(px[15:11]);
        g = int'(px[10:5]);
        b = int'(px[4:0]);
        return ((((r << 3) + (g << 2)) >> 1) + (b << 3)) >> 1;
    endfunction

    function automatic logic [1:0] px_level(input logic [15:0] px, input logic d);
        int gray;
        gray = px_gray(px);
        if (gray < TH_0) return 2'd3;
        if (gray < TH_1) return 2'd3 - {1'b0, d};
        if (gray < TH_2) return 2'd2;
        if (gray < TH_3) return 2'd2 - {1'b0, d};
        if (gray < TH_4) return 2'd1;
        if (gray < TH_5) return 2'd1 - {1'b0, d};
        return 2'd0;
    endfunction

    function automatic logic [7:0] pack_quad(input logic [3:0][15:0] px, input logic d);
        logic [7:0] q;
        q = 8'h00;
        for (int i = 0; i < 4; i++) begin
            q[2*i +: 2] = px_level(px[i], (i % 2) ? ~d : d);
        end
        return q;
    endfunction

    function automatic t_pix_out predict_bytes(input t_pix_in beat);
        t_pix_out res;
        res.byte_sent_first  = pack_quad({beat.pixel_7, beat.pixel_6, beat.pixel_5,
                                          beat.pixel_4}, beat.row_odd);
        res.byte_sent_second = pack_quad({beat.pixel_3, beat.pixel_2, beat.pixel_1,
                                          beat.pixel_0}, beat.row_odd);
        return res;
    endfunction

    // random RGB565 pixel whose gray value is exactly v (v in 18..187)
    function automatic logic [15:0] near_pixel(input int v);
        int r, g, b, rest;
        r    = $urandom_range(((v >> 1) > 31) ? 31 : (v >> 1), 0);
        rest = v - 2 * r;
        b    = $urandom_range(((rest >> 2) > 31) ? 31 : (rest >> 2),
                              (rest > 63) ? ((rest - 60) >> 2) : 0);
        g    = rest - 4 * b;
        return {r[4:0], g[5:0], b[4:0]};
    endfunction

    function automatic t_pix_in beat_of(input logic [7:0][15:0] px, input logic row);
        t_pix_in b;
        b.pixel_0 = px[0];
        b.pixel_1 = px[1];
        b.pixel_2 = px[2];
        b.pixel_3 = px[3];
        b.pixel_4 = px[4];
        b.pixel_5 = px[5];
        b.pixel_6 = px[6];
        b.pixel_7 = px[7];
        b.row_odd = row;
        return b;
    endfunction

    function automatic void add_row(input t_pix_in beat, input bit typed, input t_pix_out bytes);
        t_dir_row rw;
        rw.beat  = beat;
        rw.typed = typed;
        rw.bytes = bytes;
        dir_tab.push_back(rw);
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) return 0;
        if (sel < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic note_error(input string msg);
        if (err_count < 10) $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic send_beat(input t_pix_in beat, input bit typed, input t_pix_out bytes);
        @(negedge i_clk);
        start       <= 1'b1;
        i_pix       <= beat;
        typed_valid <= typed;
        typed_bytes <= bytes;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic idle_for(input int n);
        logic [159:0] noise;
        if (n > 0) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
            @(negedge i_clk);
            start       <= 1'b0;
            i_pix       <= noise[$bits(t_pix_in)-1:0];
            typed_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_bytes.size() == 0) begin
                    note_error($sformatf("unexpected beat first=%02h second=%02h",
                                         o_out.byte_sent_first, o_out.byte_sent_second));
                end else begin
                    want_bytes = expected_bytes.pop_front();
                    if (o_out.byte_sent_first !== want_bytes.byte_sent_first ||
                        o_out.byte_sent_second !== want_bytes.byte_sent_second) begin
                        note_error($sformatf("first exp %02h got %02h, second exp %02h got %02h",
                                             want_bytes.byte_sent_first, o_out.byte_sent_first,
                                             want_bytes.byte_sent_second,
                                             o_out.byte_sent_second));
                    end
                    pairs_checked++;
                end
            end
            if (start && !busy) begin
                expected_bytes.push_back(typed_valid ? typed_bytes : predict_bytes(i_pix));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [7:0][15:0] px;
        t_pix_in          beat;
        int               burst_left;
        int               gap;
        int               drain;

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_pix         = '0;
        typed_valid   = 1'b0;
        typed_bytes   = '0;
        err_count     = 0;
        beats_sent    = 0;
        pairs_checked = 0;
        burst_left    = 0;
        th_list       = '{TH_0, TH_1, TH_2, TH_3, TH_4, TH_5};

        for (int row = 0; row < 2; row++) begin
            px = '0;
            add_row(beat_of(px, row[0]), 1'b1, 16'hFFFF);
            px = {8{16'hFFFF}};
            add_row(beat_of(px, row[0]), 1'b1, 16'h0000);
        end
        // each band edge: pixels just below and at every threshold, both parities
        for (int t = 0; t < 6; t++) begin
            for (int row = 0; row < 2; row++) begin
                for (int k = 0; k < 8; k++) begin
                    px[k] = near_pixel((k % 4 >= 2) ? th_list[t] : th_list[t] - 1);
                end
                add_row(beat_of(px, row[0]), 1'b0, '0);
            end
        end
        for (int row = 0; row < 2; row++) begin
            px = {16'h0020, 16'h0800, 16'h0001, 16'h0000,
                  16'hFFFF, 16'h001F, 16'h07E0, 16'hF800};
            add_row(beat_of(px, row[0]), 1'b0, '0);
            px = {4{16'hAAAA, 16'h5555}};
            add_row(beat_of(px, row[0]), 1'b0, '0);
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[n]) begin
            idle_for(pick_gap());
            send_beat(dir_tab[n].beat, dir_tab[n].typed, dir_tab[n].bytes);
        end

        for (int n = 0; n < RAND_BEATS; n++) begin
            if (burst_left == 0 && $urandom_range(19) == 0) burst_left = $urandom_range(60, 20);
            if (burst_left > 0) begin
                burst_left--;
                gap = 0;
            end else begin
                gap = pick_gap();
            end
            idle_for(gap);
            for (int k = 0; k < 8; k++) begin
                if ($urandom_range(9) < 7) px[k] = 16'($urandom);
                else px[k] = near_pixel(th_list[$urandom_range(5)] + $urandom_range(5) - 3);
            end
            beat = beat_of(px, 1'($urandom_range(1)));
            send_beat(beat, 1'b0, '0);
        end
        idle_for(1);

        drain = 0;
        while (expected_bytes.size() != 0 && drain < DRAIN_MAX) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_bytes.size() != 0) begin
            note_error($sformatf("%0d beats never came out", expected_bytes.size()));
        end

        $display("Drove %0d pixel groups (%0d from the table), compared %0d byte pairs,",
                 beats_sent, dir_tab.size(), pairs_checked);
        $display("with band-edge pixels and both row parities; %0d errors", err_count);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/rgbdith_pkg.sv
hw/rtl/rgbdith_lane.sv
hw/rtl/rgbdith_merge.sv
hw/rtl/rgb565_to_2bpp_dither_packer.sv
tb/rgb565_to_2bpp_dither_packer_tb.sv
